### hw/rtl/bdc_pkg.sv
package bdc_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned PointW   = 24;
  localparam int unsigned IndexW   = 14;
  localparam int unsigned TW       = 16;
  localparam int unsigned FewPoints = 2;
  localparam logic [IndexW-1:0] SampleCountReset = 14'd5555;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } coord_t;

  typedef struct packed {
    logic signed [PointW-1:0] px;
    logic signed [PointW-1:0] py;
    logic signed [PointW-1:0] pz;
  } vec_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic load;   // shift: cell takes the point of its left neighbor
    logic step;   // one interpolation round: cell takes lerp(self, right)
  } cell_ctrl_t;

endpackage

### hw/rtl/bdc_if.sv
interface bdc_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [bdc_pkg::CoordW-1:0] coord_x;
  logic signed [bdc_pkg::CoordW-1:0] coord_y;
  logic signed [bdc_pkg::CoordW-1:0] coord_z;
  logic [bdc_pkg::IndexW-1:0]        sample_index;
  modport source (output valid, mode, coord_x, coord_y, coord_z, sample_index, input ready);
  modport sink (input valid, mode, coord_x, coord_y, coord_z, sample_index, output ready);
endinterface

interface bdc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bdc_pkg::PointW-1:0] point_x;
  logic signed [bdc_pkg::PointW-1:0] point_y;
  logic signed [bdc_pkg::PointW-1:0] point_z;
  logic                              point_valid;
  logic                              points_dropped;
  modport source (output valid, point_x, point_y, point_z, point_valid, points_dropped,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, points_dropped,
                output ready);
endinterface

### hw/rtl/bdc_div.sv
// Restoring divider: quot = floor((idx << 16) / den), one quotient bit per cycle.
module bdc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bdc_pkg::IndexW-1:0]     idx,
  input  logic [bdc_pkg::IndexW-1:0]     den,
  output logic                           done,
  output logic [bdc_pkg::TW-1:0]         quot
);
  localparam int unsigned NumW = bdc_pkg::IndexW + bdc_pkg::TW;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]            num;
  logic [bdc_pkg::IndexW:0]   rem;
  logic [NumW-1:0]            q;
  logic [CntW-1:0]            cnt;
  logic                       busy;
  logic [bdc_pkg::IndexW:0]   shifted;
  logic [bdc_pkg::IndexW:0]   diff;

  assign shifted = {rem[bdc_pkg::IndexW-1:0], num[NumW-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        num  <= {idx, {bdc_pkg::TW{1'b0}}};
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        num <= {num[NumW-2:0], 1'b0};
        if (!diff[bdc_pkg::IndexW]) begin
          rem <= diff;
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // idx < den keeps the quotient within 16 bits
  assign quot = q[bdc_pkg::TW-1:0];
endmodule

### hw/rtl/bdc_cell.sv
// One slot of the interpolation row. Holds a point; on load takes the point of its
// left neighbor, on step takes floor(((1-t)*self + t*right)) per axis, computed as
// self + floor(t*(right-self)/65536).
module bdc_cell (
  input  logic                      clk,
  input  bdc_pkg::cell_ctrl_t       ctrl,
  input  bdc_pkg::vec_t             left,
  input  bdc_pkg::vec_t             right,
  input  logic [bdc_pkg::TW-1:0]    t,
  output bdc_pkg::vec_t             value
);
  localparam int unsigned DW = bdc_pkg::PointW + 1;
  localparam int unsigned PW = DW + bdc_pkg::TW + 1;

  function automatic logic signed [bdc_pkg::PointW-1:0] lerp(
      input logic signed [bdc_pkg::PointW-1:0] a,
      input logic signed [bdc_pkg::PointW-1:0] b,
      input logic [bdc_pkg::TW-1:0] tt);
    logic signed [DW-1:0] d;
    logic signed [PW-1:0] p;
    d = DW'(b) - DW'(a);
    p = PW'(d) * $signed(PW'({1'b0, tt}));
    lerp = a + bdc_pkg::PointW'(p >>> bdc_pkg::TW);
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= left;
    end else if (ctrl.step) begin
      value.px <= lerp(value.px, right.px, t);
      value.py <= lerp(value.py, right.py, t);
      value.pz <= lerp(value.pz, right.pz, t);
    end
  end
endmodule

### hw/rtl/bezier_de_casteljau_evaluator.sv
// Channel | direction | payload
// in      | sink      | mode, coord_x, coord_y, coord_z, sample_index
// out     | source    | point_x, point_y, point_z, point_valid, points_dropped
//
// Clear and append complete at the edge that accepts them; the next item can follow at once.
// An evaluation with three or more points computes t in the serial divider,
// shifts the point_count points into the cell row, runs point_count-1 rounds
// and registers the result. Few-point evaluations pass the store read state
// (S_READ), then the result state (S_PICK); an invalid
// sample is registered at the edge that accepts it.
// rst is synchronous and clears count, flag, sequencer and output valid.
// A result waits in the output register; a new item is taken only once it is empty.
module bezier_de_casteljau_evaluator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdc_pkg::IndexW-1:0]       cfg_data,
  bdc_in_if.sink                           in_ch,
  bdc_out_if.source                        out_ch
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_PICK = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_LOAD = 7'b0010000,
    S_RUN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                      state;
  logic [bdc_pkg::IndexW-1:0]  sample_count;
  logic [CW-1:0]               point_count;
  logic                        overflow_flag;
  bdc_pkg::coord_t             point_store [MAX_POINTS];
  bdc_pkg::coord_t             rd_pt;
  logic [AW-1:0]               rd_addr;
  logic [CW-1:0]               rounds;
  logic [CW-1:0]               lcnt;
  logic [bdc_pkg::TW-1:0]      t;
  logic                        div_start, div_done;
  logic [bdc_pkg::TW-1:0]      div_q;
  bdc_pkg::cell_ctrl_t         ctrl;
  bdc_pkg::vec_t               cell_val [MAX_POINTS];
  logic                        in_fire, few, idx_ok;

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign few         = point_count <= CW'(bdc_pkg::FewPoints);
  assign idx_ok      = (sample_count != '0) && (in_ch.sample_index < sample_count);

  always_ff @(posedge clk) begin
    if (rst) sample_count <= bdc_pkg::SampleCountReset;
    else if (cfg_we) sample_count <= cfg_data;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.mode == bdc_pkg::MODE_APPEND && point_count < CW'(MAX_POINTS))
      point_store[point_count[AW-1:0]] <= '{in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
    rd_pt <= point_store[rd_addr];
  end

  // cell row: the store is read from the top entry down and shifted in at cell 0,
  // so after point_count shifts cell j holds entry j
  assign ctrl.load = (state == S_LOAD);
  assign ctrl.step = (state == S_RUN);

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    bdc_pkg::vec_t left;
    bdc_pkg::vec_t right;
    if (j == 0) begin : g_first
      assign left = {rd_pt.coord_x, 8'd0, rd_pt.coord_y, 8'd0, rd_pt.coord_z, 8'd0};
    end else begin : g_next
      assign left = cell_val[j-1];
    end
    if (j == MAX_POINTS - 1) begin : g_last
      assign right = cell_val[j];
    end else begin : g_mid
      assign right = cell_val[j+1];
    end
    bdc_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left    (left),
      .right   (right),
      .t       (t),
      .value   (cell_val[j])
    );
  end

  assign div_start = in_fire && in_ch.mode == bdc_pkg::MODE_EVAL && !few && idx_ok;

  bdc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .idx   (in_ch.sample_index),
    .den   (sample_count),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= '0;
      overflow_flag <= 1'b0;
      rd_addr       <= '0;
      out_ch.valid  <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.mode)
              bdc_pkg::MODE_CLEAR: begin
                point_count   <= '0;
                overflow_flag <= 1'b0;
              end
              bdc_pkg::MODE_APPEND: begin
                if (point_count < CW'(MAX_POINTS)) point_count <= point_count + 1'b1;
                else overflow_flag <= 1'b1;
              end
              bdc_pkg::MODE_EVAL: begin
                if (few) begin
                  if ({{(bdc_pkg::IndexW){1'b0}}, point_count} >
                      (bdc_pkg::IndexW + CW)'(in_ch.sample_index)) begin
                    rd_addr <= in_ch.sample_index[AW-1:0];
                    state   <= S_READ;
                  end else begin
                    out_ch.valid       <= 1'b1;
                    out_ch.point_valid <= 1'b0;
                    out_ch.point_x     <= '0;
                    out_ch.point_y     <= '0;
                    out_ch.point_z     <= '0;
                    out_ch.points_dropped <= overflow_flag;
                  end
                end else if (idx_ok) begin
                  state   <= S_DIV;
                  rounds  <= point_count - 1'b1;
                  rd_addr <= AW'(point_count - 1'b1);
                end else begin
                  out_ch.valid       <= 1'b1;
                  out_ch.point_valid <= 1'b0;
                  out_ch.point_x     <= '0;
                  out_ch.point_y     <= '0;
                  out_ch.point_z     <= '0;
                  out_ch.points_dropped <= overflow_flag;
                end
              end
              default: ;
            endcase
          end
        end
        // the registered store read takes the addressed entry at this edge
        S_READ: state <= S_PICK;
        S_PICK: begin
          out_ch.valid       <= 1'b1;
          out_ch.point_valid <= 1'b1;
          out_ch.point_x     <= {rd_pt.coord_x, 8'd0};
          out_ch.point_y     <= {rd_pt.coord_y, 8'd0};
          out_ch.point_z     <= {rd_pt.coord_z, 8'd0};
          out_ch.points_dropped <= overflow_flag;
          state <= S_IDLE;
        end
        S_DIV: begin
          // the top entry already sits in rd_pt; advance the read address
          if (div_done) begin
            t     <= div_q;
            lcnt  <= point_count;
            if (rd_addr != '0) rd_addr <= rd_addr - 1'b1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          lcnt <= lcnt - 1'b1;
          if (rd_addr != '0) rd_addr <= rd_addr - 1'b1;
          if (lcnt == CW'(1)) state <= S_RUN;
        end
        S_RUN: begin
          rounds <= rounds - 1'b1;
          if (rounds == CW'(1)) begin
            state <= S_OUT;
          end
        end
        // after the last round cell 0 holds the curve point
        S_OUT: begin
          out_ch.valid          <= 1'b1;
          out_ch.point_x        <= cell_val[0].px;
          out_ch.point_y        <= cell_val[0].py;
          out_ch.point_z        <= cell_val[0].pz;
          out_ch.point_valid    <= 1'b1;
          out_ch.points_dropped <= overflow_flag;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS)) else $error("point count above capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_div_to_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> (state == S_LOAD)) else $error("divider handoff lost");
`endif
endmodule
